[rtl/square_wave_tone_generator_assert.svh]
// ----------------------------------------------------------------------------
// Tone generator assertion macros
// Concurrent assertion wrappers shared by the tone generator modules.
// ----------------------------------------------------------------------------
`ifndef SQUARE_WAVE_TONE_GENERATOR_ASSERT_SVH
`define SQUARE_WAVE_TONE_GENERATOR_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define STG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tone generator assertion failed");
// next-cycle implication
`define STG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tone generator assertion failed");
`else
`define STG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define STG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/stg_pkg.sv]
// ----------------------------------------------------------------------------
// Tone generator package
// Widths, codes, constants, controller states, command/status types and prescaler shifts.
// ----------------------------------------------------------------------------
package stg_pkg;

	localparam int STG_CLOCK_HZ = 8000000;

	localparam int FREQ_W = 16;
	localparam int DUR_W  = 16;
	localparam int CMP_W  = 16;
	localparam int TOG_W  = 24;
	localparam int PSC_W  = 10;
	localparam int SEL_W  = 3;
	localparam int DIV_W  = FREQ_W + DUR_W + 1;
	localparam int DVS_W  = 16;
	localparam int CNT_W  = $clog2(DIV_W + 1);

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_STOP  = 2'd1;
	localparam logic [1:0] FUNC_TICK  = 2'd2;

	localparam logic [FREQ_W-1:0] MIN_FREQ = FREQ_W'(50);

	// floor(y / 125) = (y * TOG_RCP) >> TOG_RCP_SH for any y below 2^30
	localparam int               TOG_RCP_W  = 31;
	localparam int               TOG_RCP_SH = 37;
	localparam logic [TOG_RCP_W-1:0] TOG_RCP = 31'd1099511628;

	typedef enum logic [2:0] {
		S_IDLE,
		S_QLOAD,
		S_QRUN,
		S_COMMIT
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic div_start;
		logic store_q;
		logic commit_start;
		logic do_stop;
		logic do_tick;
		logic load_out;
		logic reject;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic freq_low;
	} dp_status_t;

	function automatic logic [3:0] psc_shift(input logic [SEL_W-1:0] sel);
		logic [3:0] sh;
		unique case (sel)
			3'd0: sh = 4'd0;
			3'd1: sh = 4'd1;
			3'd2: sh = 4'd2;
			3'd3: sh = 4'd3;
			3'd4: sh = 4'd4;
			3'd5: sh = 4'd6;
			3'd6: sh = 4'd8;
			default: sh = 4'd10;
		endcase
		return sh;
	endfunction

endpackage

[rtl/stg_div.sv]
// ----------------------------------------------------------------------------
// Tone generator divider
// Restoring divider, one quotient bit per cycle, done pulse after the last.
// ----------------------------------------------------------------------------
module stg_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [stg_pkg::DIV_W-1:0] dividend,
	input  logic [stg_pkg::DVS_W-1:0] divisor,
	output logic [stg_pkg::DIV_W-1:0] quotient,
	output logic                      done
);
	import stg_pkg::*;

	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             fit;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fit   = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fit};
			rem_q <= fit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[rtl/stg_dp.sv]
// ----------------------------------------------------------------------------
// Tone generator datapath
// Tone state, tick counters, product, divider, prescaler pick, result register.
// ----------------------------------------------------------------------------
`include "square_wave_tone_generator_assert.svh"

module stg_dp #(
	parameter int CLOCK_HZ = stg_pkg::STG_CLOCK_HZ
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  stg_pkg::dp_cmd_t           cmd,
	output stg_pkg::dp_status_t        status,
	input  logic [stg_pkg::FREQ_W-1:0] frequency_hz,
	input  logic [stg_pkg::DUR_W-1:0]  duration_ms,
	output logic                       pin_level,
	output logic                       tone_active,
	output logic                       start_rejected
);
	import stg_pkg::*;

	localparam logic [DIV_W-1:0] HALF_CLK = DIV_W'(CLOCK_HZ / 2);
	localparam logic [DIV_W-1:0] FIT_MAX  = DIV_W'(32'h10000);
	localparam int               PRD_W    = FREQ_W + DUR_W;
	localparam int               MUL_W    = PRD_W - 2 + TOG_RCP_W;

	logic                      pin_q, active_q, endless_q;
	logic [TOG_W-1:0]          tog_q;
	logic [CMP_W-1:0]          cmp_q;
	logic [SEL_W-1:0]          sel_q;
	logic [PSC_W-1:0]          psc_q;
	logic [CMP_W-1:0]          per_q;
	logic                      pin_d, active_d, endless_d;
	logic [TOG_W-1:0]          tog_d;
	logic [CMP_W-1:0]          cmp_d;
	logic [SEL_W-1:0]          sel_d;
	logic [PSC_W-1:0]          psc_d;
	logic [CMP_W-1:0]          per_d;

	logic [FREQ_W-1:0]         freq_q;
	logic [DUR_W-1:0]          dur_q;
	logic [PRD_W-1:0]          prod_q;
	logic [MUL_W-1:0]          tog_mul;
	logic [TOG_W-1:0]          tog_n_q;
	logic [DIV_W-1:0]          q_q;
	logic [DIV_W-1:0]          div_quo;
	logic                      div_done;

	logic [SEL_W-1:0]          pick_sel;
	logic [CMP_W-1:0]          pick_cmp;
	logic [PSC_W:0]            psc_inc;
	logic [PSC_W:0]            psc_div;

	stg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (HALF_CLK),
		.divisor  (freq_q),
		.quotient (div_quo),
		.done     (div_done)
	);

	assign status.div_done = div_done;
	assign status.freq_low = frequency_hz < MIN_FREQ;

	// toggle count: 2 * f * d / 1000 = (f * d / 4) / 125
	assign tog_mul = prod_q[PRD_W-1:2] * TOG_RCP;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			freq_q <= frequency_hz;
			dur_q  <= duration_ms;
		end
		prod_q  <= freq_q * dur_q;
		tog_n_q <= tog_mul[TOG_RCP_SH+TOG_W-1:TOG_RCP_SH];
		if (cmd.store_q) begin
			q_q <= div_quo;
		end
	end

	// smallest fitting prescaler wins
	always_comb begin
		logic [DIV_W-1:0] v;
		pick_sel = SEL_W'(7);
		pick_cmp = '1;
		for (int s = 7; s >= 0; s--) begin
			v = q_q >> psc_shift(SEL_W'(s));
			if (v <= FIT_MAX) begin
				pick_sel = SEL_W'(s);
				pick_cmp = (v == '0) ? '0 : CMP_W'(v - DIV_W'(1));
			end
		end
	end

	assign psc_inc = {1'b0, psc_q} + (PSC_W+1)'(1);
	assign psc_div = (PSC_W+1)'(1) << psc_shift(sel_q);

	always_comb begin
		pin_d     = pin_q;
		active_d  = active_q;
		endless_d = endless_q;
		tog_d     = tog_q;
		cmp_d     = cmp_q;
		sel_d     = sel_q;
		psc_d     = psc_q;
		per_d     = per_q;
		priority if (cmd.commit_start) begin
			sel_d     = pick_sel;
			cmp_d     = pick_cmp;
			endless_d = (dur_q == '0);
			tog_d     = (dur_q == '0) ? '0 : tog_n_q;
			pin_d     = 1'b0;
			psc_d     = '0;
			per_d     = '0;
			active_d  = 1'b1;
		end else if (cmd.do_stop) begin
			active_d  = 1'b0;
			pin_d     = 1'b0;
			endless_d = 1'b0;
			psc_d     = '0;
			per_d     = '0;
		end else if (cmd.do_tick && active_q) begin
			if (psc_inc < psc_div) begin
				psc_d = psc_inc[PSC_W-1:0];
			end else begin
				psc_d = '0;
				if (per_q == cmp_q) begin
					per_d = '0;
					if (endless_q || tog_q != '0) begin
						if (!endless_q) begin
							tog_d = tog_q - TOG_W'(1);
						end
						pin_d = ~pin_q;
					end else begin
						active_d  = 1'b0;
						pin_d     = 1'b0;
						endless_d = 1'b0;
					end
				end else begin
					per_d = per_q + CMP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_q     <= 1'b0;
			active_q  <= 1'b0;
			endless_q <= 1'b0;
			tog_q     <= '0;
			cmp_q     <= '0;
			sel_q     <= '0;
			psc_q     <= '0;
			per_q     <= '0;
		end else begin
			pin_q     <= pin_d;
			active_q  <= active_d;
			endless_q <= endless_d;
			tog_q     <= tog_d;
			cmp_q     <= cmp_d;
			sel_q     <= sel_d;
			psc_q     <= psc_d;
			per_q     <= per_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			pin_level      <= pin_d;
			tone_active    <= active_d;
			start_rejected <= cmd.reject;
		end
	end

	`STG_ASSERT_IMP(a_idle_counters_clear, clk, arst_n, !active_q, psc_q == '0 && per_q == '0)
	`STG_ASSERT_IMP(a_pin_low_when_idle, clk, arst_n, !active_q, !pin_q)
	`STG_ASSERT_NXT(a_endless_holds_count, clk, arst_n, endless_q && !cmd.commit_start,
		$stable(tog_q))

endmodule

[rtl/stg_ctrl.sv]
// ----------------------------------------------------------------------------
// Tone generator controller
// Sequences item decode, the frequency division and the start commit; owns handshakes.
// ----------------------------------------------------------------------------
`include "square_wave_tone_generator_assert.svh"

module stg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	output logic                out_valid,
	input  logic                out_stall,
	input  stg_pkg::dp_status_t status,
	output stg_pkg::dp_cmd_t    cmd
);
	import stg_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        slot_free;
	logic        accept;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = !(state_q == S_IDLE && slot_free);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && func == FUNC_START && !status.freq_low) begin
					state_d = S_QLOAD;
				end
			end
			S_QLOAD: state_d = S_QRUN;
			S_QRUN: begin
				if (status.div_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (func == FUNC_START) begin
						cmd.capture  = !status.freq_low;
						cmd.load_out = status.freq_low;
						cmd.reject   = status.freq_low;
					end else begin
						cmd.do_stop  = (func == FUNC_STOP);
						cmd.do_tick  = (func == FUNC_TICK);
						cmd.load_out = 1'b1;
					end
				end
			end
			S_QLOAD: cmd.div_start = 1'b1;
			S_QRUN:  cmd.store_q = status.div_done;
			S_COMMIT: begin
				cmd.commit_start = slot_free;
				cmd.load_out     = slot_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`STG_ASSERT_IMP(a_busy_stalls_input, clk, arst_n, state_q != S_IDLE, in_stall)
	`STG_ASSERT_IMP(a_done_only_running, clk, arst_n, status.div_done, state_q == S_QRUN)
	`STG_ASSERT_NXT(a_result_presented, clk, arst_n, cmd.load_out, out_valid)

endmodule

[rtl/square_wave_tone_generator.sv]
// ----------------------------------------------------------------------------
// Square-wave tone generator
// Piezo tone generator: start, stop and clock-tick items, one result per item.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   func, frequency_hz, duration_ms
//   out      output     out_valid/out_stall pin_level, tone_active, start_rejected
//
// Tick, stop, rejected start and unused codes are handled in the idle state;
// an accepted start holds the input through the load, one 33-step pass of the
// bit-serial divider (half clock over frequency), done and the commit;
// the toggle count comes from a registered reciprocal multiply meanwhile.
// Reset clears the tone state and the result register valid; no clearing pass.
// A stalled result holds; a new item is taken in the cycle the result leaves.
// ----------------------------------------------------------------------------
module square_wave_tone_generator #(
	parameter int CLOCK_HZ = stg_pkg::STG_CLOCK_HZ
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 func,
	input  logic [stg_pkg::FREQ_W-1:0] frequency_hz,
	input  logic [stg_pkg::DUR_W-1:0]  duration_ms,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       pin_level,
	output logic                       tone_active,
	output logic                       start_rejected
);
	import stg_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	stg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	stg_dp #(
		.CLOCK_HZ (CLOCK_HZ)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.frequency_hz   (frequency_hz),
		.duration_ms    (duration_ms),
		.pin_level      (pin_level),
		.tone_active    (tone_active),
		.start_rejected (start_rejected)
	);

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square-wave tone generator testbench
// Drives start, stop, tick and unused-code transfers in random bursts against a
// randomly stalling receiver, and checks every status transfer field by field
// against a cycle-free model of the tone state kept in this bench or a literal
// table result. A short directed table covers edge cases before the random part.
// ----------------------------------------------------------------------------
module tb_top;
	import stg_pkg::*;

	localparam logic [1:0]  FUNC_NONE = 2'd3;
	localparam int unsigned RUN_LIMIT = 3000000;
	localparam int unsigned N_RAND    = 80;
	localparam int unsigned DRAIN     = 100;
	localparam logic [7:0][3:0] DIV_SHIFT =
		{4'd10, 4'd8, 4'd6, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0};

	typedef struct packed {
		logic pin;
		logic active;
		logic rej;
	} tone_out_t;

	typedef struct packed {
		logic [1:0]  f;
		logic [15:0] fr;
		logic [15:0] du;
		logic [15:0] rpt;
		logic        lit;
		tone_out_t   res;
	} dir_row_t;

	localparam int N_DIR = 25;
	localparam dir_row_t DIR_TAB [N_DIR] = '{
		'{FUNC_TICK,  16'd0,     16'd0,     16'd1,     1'b1, 3'b000},
		'{FUNC_STOP,  16'd0,     16'd0,     16'd1,     1'b1, 3'b000},
		'{FUNC_NONE,  16'hffff,  16'hffff,  16'd1,     1'b1, 3'b000},
		'{FUNC_START, 16'd0,     16'd0,     16'd1,     1'b1, 3'b001},
		'{FUNC_START, 16'd49,    16'hffff,  16'd1,     1'b1, 3'b001},
		'{FUNC_START, 16'd50,    16'd0,     16'd1,     1'b1, 3'b010},
		'{FUNC_TICK,  16'hffff,  16'hffff,  16'd20,    1'b0, 3'b000},
		'{FUNC_START, 16'hffff,  16'hffff,  16'd1,     1'b1, 3'b010},
		'{FUNC_TICK,  16'd0,     16'd0,     16'd70,    1'b0, 3'b000},
		'{FUNC_START, 16'd49,    16'd0,     16'd1,     1'b0, 3'b000},
		'{FUNC_NONE,  16'd0,     16'd0,     16'd1,     1'b0, 3'b000},
		'{FUNC_STOP,  16'hffff,  16'hffff,  16'd1,     1'b1, 3'b000},
		'{FUNC_TICK,  16'd0,     16'd0,     16'd1,     1'b1, 3'b000},
		'{FUNC_START, 16'd62,    16'd0,     16'd1,     1'b1, 3'b010},
		'{FUNC_START, 16'd61,    16'hffff,  16'd1,     1'b1, 3'b010},
		'{FUNC_STOP,  16'd0,     16'd0,     16'd1,     1'b1, 3'b000},
		'{FUNC_START, 16'd499,   16'd1,     16'd1,     1'b1, 3'b010},
		'{FUNC_TICK,  16'd0,     16'd0,     16'd10,    1'b0, 3'b000},
		'{FUNC_START, 16'hffff,  16'd1,     16'd1,     1'b1, 3'b010},
		'{FUNC_TICK,  16'd0,     16'd0,     16'd70,    1'b0, 3'b000},
		'{FUNC_START, 16'd1000,  16'd0,     16'd1,     1'b1, 3'b010},
		'{FUNC_TICK,  16'd0,     16'd0,     16'd10,    1'b0, 3'b000},
		'{FUNC_START, 16'h8000,  16'h5555,  16'd1,     1'b1, 3'b010},
		'{FUNC_TICK,  16'd0,     16'd0,     16'd10,    1'b0, 3'b000},
		'{FUNC_STOP,  16'd0,     16'd0,     16'd1,     1'b1, 3'b000}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = 2'd0;
	logic [15:0] frequency_hz = 16'd0;
	logic [15:0] duration_ms = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        pin_level;
	logic        tone_active;
	logic        start_rejected;

	// tone state
	logic        mdl_pin, mdl_active, mdl_endless;
	logic [23:0] mdl_toggles;
	logic [15:0] mdl_cmp;
	logic [2:0]  mdl_sel;
	logic [10:0] mdl_psc;
	logic [15:0] mdl_period;

	tone_out_t   tone_status_q [$];
	int unsigned burst_left = 0;
	int unsigned cyc = 0;
	logic [9:0]  rx_phase = '0;
	int unsigned errors = 0;
	int unsigned n_xfer = 0, n_result = 0, n_start = 0, n_reject = 0, n_stop = 0;
	int unsigned n_toggle = 0, n_runout = 0;

	square_wave_tone_generator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.frequency_hz   (frequency_hz),
		.duration_ms    (duration_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pin_level      (pin_level),
		.tone_active    (tone_active),
		.start_rejected (start_rejected)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void tone_halt();
		mdl_active  = 1'b0;
		mdl_pin     = 1'b0;
		mdl_endless = 1'b0;
		mdl_psc     = '0;
		mdl_period  = '0;
	endfunction

	function automatic tone_out_t tone_step(input logic [1:0] f, input logic [15:0] fr,
			input logic [15:0] du);
		tone_out_t r;
		longint unsigned q, v, c, prod;
		logic found;
		r.rej = 1'b0;
		case (f)
			FUNC_START: begin
				if (fr < MIN_FREQ) begin
					r.rej = 1'b1;
					n_reject++;
				end else begin
					q = (longint'(STG_CLOCK_HZ) / 2) / fr;
					found = 1'b0;
					mdl_sel = 3'd7;
					mdl_cmp = 16'hffff;
					for (int s = 0; s < 8; s++) begin
						v = q >> DIV_SHIFT[s];
						c = (v == 0) ? 0 : v - 1;
						if (!found && c <= 64'hffff) begin
							found = 1'b1;
							mdl_sel = 3'(s);
							mdl_cmp = 16'(c);
						end
					end
					if (du == 16'd0) begin
						mdl_endless = 1'b1;
						mdl_toggles = '0;
					end else begin
						prod = (longint'(fr) * longint'(du) * 2) / 1000;
						mdl_endless = 1'b0;
						mdl_toggles = 24'(prod);
					end
					mdl_pin    = 1'b0;
					mdl_psc    = '0;
					mdl_period = '0;
					mdl_active = 1'b1;
					n_start++;
				end
			end
			FUNC_STOP: begin
				tone_halt();
				n_stop++;
			end
			FUNC_TICK: begin
				if (mdl_active) begin
					mdl_psc = mdl_psc + 11'd1;
					if (mdl_psc >= (11'd1 << DIV_SHIFT[mdl_sel])) begin
						mdl_psc = '0;
						if (mdl_period == mdl_cmp) begin
							mdl_period = '0;
							if (mdl_endless || mdl_toggles != '0) begin
								if (!mdl_endless)
									mdl_toggles = mdl_toggles - 24'd1;
								mdl_pin = ~mdl_pin;
								n_toggle++;
							end else begin
								tone_halt();
								n_runout++;
							end
						end else begin
							mdl_period = mdl_period + 16'd1;
						end
					end
				end
			end
			default: ;
		endcase
		r.pin    = mdl_pin;
		r.active = mdl_active;
		return r;
	endfunction

	task automatic drive_cmd(input logic [1:0] f, input logic [15:0] fr, input logic [15:0] du,
			input logic lit, input tone_out_t lit_res);
		tone_out_t p;
		@(negedge clk);
		if (burst_left == 0) begin
			in_valid     <= 1'b0;
			func         <= 2'($urandom);
			frequency_hz <= 16'($urandom);
			duration_ms  <= 16'($urandom);
			repeat ($urandom_range(1, 5)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 2000)
				: $urandom_range(1, 40);
		end
		in_valid     <= 1'b1;
		func         <= f;
		frequency_hz <= fr;
		duration_ms  <= du;
		burst_left--;
		do @(posedge clk); while (in_stall !== 1'b0);
		p = tone_step(f, fr, du);
		tone_status_q.push_back(lit ? lit_res : p);
		n_xfer++;
	endtask

	task automatic check_bit(input string name, input logic e, input logic a);
		if (a !== e) begin
			$display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, e, a);
			errors++;
		end
	endtask

	// receiver stall pattern: free, sparse random, periodic, heavy random
	always @(negedge clk) begin
		rx_phase <= rx_phase + 10'd1;
		case (rx_phase[9:8])
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(0, 3) == 0);
			2'd2: out_stall <= (rx_phase[2:0] < 3'd3);
			default: out_stall <= ($urandom_range(0, 1) == 1);
		endcase
	end

	always @(posedge clk) begin
		tone_out_t e;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			n_result++;
			if (tone_status_q.size() == 0) begin
				$display("%0t: unexpected status transfer, pin %0b active %0b rejected %0b",
					$time, pin_level, tone_active, start_rejected);
				errors++;
			end else begin
				e = tone_status_q.pop_front();
				check_bit("pin_level", e.pin, pin_level);
				check_bit("tone_active", e.active, tone_active);
				check_bit("start_rejected", e.rej, start_rejected);
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == RUN_LIMIT) begin
			$display("%0t: timeout with %0d status transfers pending", $time,
				tone_status_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int unsigned r, run;
		logic [15:0] fr, du;
		mdl_pin = 1'b0;
		mdl_active = 1'b0;
		mdl_endless = 1'b0;
		mdl_toggles = '0;
		mdl_cmp = '0;
		mdl_sel = '0;
		mdl_psc = '0;
		mdl_period = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIR; i++)
			for (int k = 0; k < DIR_TAB[i].rpt; k++)
				drive_cmd(DIR_TAB[i].f, DIR_TAB[i].fr, DIR_TAB[i].du, DIR_TAB[i].lit,
					DIR_TAB[i].res);

		for (int k = 0; k < N_RAND; k++) begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				case ($urandom_range(0, 9))
					0: fr = 16'($urandom_range(0, 49));
					1, 2, 3: fr = 16'($urandom_range(50, 65535));
					default: fr = 16'($urandom_range(1000, 65535));
				endcase
				case ($urandom_range(0, 4))
					0: du = 16'd0;
					1, 2: du = 16'($urandom_range(1, 3));
					default: du = 16'($urandom);
				endcase
				drive_cmd(FUNC_START, fr, du, 1'b0, '0);
			end else if (r < 42) begin
				drive_cmd(FUNC_STOP, 16'($urandom), 16'($urandom), 1'b0, '0);
			end else if (r < 46) begin
				drive_cmd(FUNC_NONE, 16'($urandom), 16'($urandom), 1'b0, '0);
			end else begin
				run = $urandom_range(1, 8);
				repeat (run) drive_cmd(FUNC_TICK, 16'($urandom), 16'($urandom), 1'b0, '0);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (tone_status_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Covered %0d transfers in %0d cycles: %0d starts, %0d rejected, %0d stops.",
			n_xfer, cyc, n_start, n_reject, n_stop);
		$display("Pin toggled %0d times, %0d tones ran out on their own, %0d errors.",
			n_toggle, n_runout, errors);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/stg_pkg.sv
rtl/stg_div.sv
rtl/stg_dp.sv
rtl/stg_ctrl.sv
rtl/square_wave_tone_generator.sv
bench/tb_top.sv
